// File: hdl/klip_pkg.sv
// ----------------------------------------------------------------------------
// klip_pkg
// Shared widths and codes for the keyed lifo id pool.
// ----------------------------------------------------------------------------
`default_nettype none

package klip_pkg;

	localparam int VALUE_W  = 64;
	localparam int MODE_W   = 2;
	localparam int STATUS_W = 3;

	// request modes
	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ERASE  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TAKE   = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] STAT_OK      = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_DUP     = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL    = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_MISSING = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_EMPTY   = 3'd4;

	typedef logic [VALUE_W-1:0] value_t;

endpackage

`default_nettype wire

// File: hdl/klip_ram.sv
// ----------------------------------------------------------------------------
// klip_ram
// Generic single write port, single read port ram with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module klip_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// File: hdl/keyed_lifo_id_pool.sv
// ----------------------------------------------------------------------------
// keyed_lifo_id_pool
// Pool of distinct 64-bit ids: insert, erase by value, take newest.
// ----------------------------------------------------------------------------
// Usage:
//   A request (mode, item_value) is taken on the input channel when in_valid
//   is high and in_stall is low. One result (status, taken_value,
//   entries_held) comes back per request on the output channel, handed over
//   when out_valid is high and out_stall is low.
//   Entries live in one ram, oldest at slot 0. Insert and erase walk the
//   held entries once, one ram read per cycle; erase moves every later entry
//   down one slot during the same walk. Take reads only the newest slot.
//   One request is in work at a time; the next request is taken at the
//   earliest in the cycle after the result is registered, also while that
//   result waits on the output.
//   If the receiver stalls, the result holds steady and a finished request
//   waits in its final state until the output register frees up.
//   Reset empties the pool and drops any pending result; the ram contents
//   are left as they are and need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_lifo_id_pool #(
	parameter int POOL_DEPTH = 64
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// request channel
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [klip_pkg::MODE_W-1:0]         mode,
	input  wire logic signed [klip_pkg::VALUE_W-1:0] item_value,
	// result channel
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic      [klip_pkg::STATUS_W-1:0]       status,
	output logic signed [klip_pkg::VALUE_W-1:0]      taken_value,
	output logic      [$clog2(POOL_DEPTH+1)-1:0]     entries_held
);

	localparam int CNT_W  = $clog2(POOL_DEPTH + 1);
	localparam int ADDR_W = $clog2(POOL_DEPTH);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	state_t                        state_q;
	logic [CNT_W-1:0]              count_q;
	logic [CNT_W-1:0]              rd_ptr_q;
	logic [klip_pkg::MODE_W-1:0]   mode_q;
	klip_pkg::value_t              key_q;
	klip_pkg::value_t              taken_q;
	logic                          found_q;
	logic                          valid_s1;
	logic [ADDR_W-1:0]             idx_s1;

	logic                          accept;
	logic                          rd_en;
	klip_pkg::value_t              rd_data;
	logic                          wr_en;
	logic [ADDR_W-1:0]             wr_addr;
	klip_pkg::value_t              wr_data;
	logic                          out_free;
	logic                          fin_go;
	logic                          hit;

	logic [klip_pkg::STATUS_W-1:0] fin_status;
	logic [CNT_W-1:0]              fin_count;
	klip_pkg::value_t              fin_taken;
	logic                          fin_ins_wr;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && (state_q == ST_IDLE);
	assign out_free = !out_valid || !out_stall;
	assign fin_go   = (state_q == ST_FIN) && out_free;
	assign rd_en    = (state_q == ST_RUN) && (rd_ptr_q != count_q);
	assign hit      = valid_s1 && (rd_data == key_q);

	// outcome of the request once the walk is over
	always_comb begin
		fin_status = klip_pkg::STAT_OK;
		fin_count  = count_q;
		fin_taken  = '0;
		fin_ins_wr = 1'b0;
		unique case (mode_q)
			klip_pkg::MODE_INSERT: begin
				if (found_q) begin
					fin_status = klip_pkg::STAT_DUP;
				end else if (count_q == CNT_W'(POOL_DEPTH)) begin
					fin_status = klip_pkg::STAT_FULL;
				end else begin
					fin_count  = count_q + CNT_W'(1);
					fin_ins_wr = 1'b1;
				end
			end
			klip_pkg::MODE_ERASE: begin
				if (found_q) begin
					fin_count = count_q - CNT_W'(1);
				end else begin
					fin_status = klip_pkg::STAT_MISSING;
				end
			end
			klip_pkg::MODE_TAKE: begin
				if (count_q == '0) begin
					fin_status = klip_pkg::STAT_EMPTY;
				end else begin
					fin_count = count_q - CNT_W'(1);
					fin_taken = taken_q;
				end
			end
			default: begin
			end
		endcase
	end

	// one write port: compaction during the erase walk, append at the end of insert
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = count_q[ADDR_W-1:0];
		wr_data = key_q;
		if ((state_q == ST_RUN) && valid_s1 && found_q && (mode_q == klip_pkg::MODE_ERASE)) begin
			wr_en   = 1'b1;
			wr_addr = idx_s1 - ADDR_W'(1);
			wr_data = rd_data;
		end else if (fin_go && fin_ins_wr) begin
			wr_en = 1'b1;
		end
	end

	klip_ram #(
		.WIDTH (klip_pkg::VALUE_W),
		.DEPTH (POOL_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_ptr_q[ADDR_W-1:0]),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			rd_ptr_q  <= '0;
			found_q   <= 1'b0;
			valid_s1  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			valid_s1 <= rd_en;
			if (fin_go) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RUN;
						found_q <= 1'b0;
						if ((mode == klip_pkg::MODE_INSERT) || (mode == klip_pkg::MODE_ERASE)) begin
							rd_ptr_q <= '0;
						end else if ((mode == klip_pkg::MODE_TAKE) && (count_q != '0)) begin
							rd_ptr_q <= count_q - CNT_W'(1);
						end else begin
							// nothing to read
							rd_ptr_q <= count_q;
						end
					end
				end
				ST_RUN: begin
					if (rd_en) begin
						rd_ptr_q <= rd_ptr_q + CNT_W'(1);
					end
					if (hit && (mode_q != klip_pkg::MODE_TAKE)) begin
						found_q <= 1'b1;
					end
					if (!rd_en && !valid_s1) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						count_q <= fin_count;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode;
			key_q  <= item_value;
		end
		if (rd_en) begin
			idx_s1 <= rd_ptr_q[ADDR_W-1:0];
		end
		if (valid_s1 && (mode_q == klip_pkg::MODE_TAKE)) begin
			taken_q <= rd_data;
		end
		if (fin_go) begin
			status       <= fin_status;
			taken_value  <= fin_taken;
			entries_held <= fin_count;
		end
	end

	// the pool never holds more than its depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(POOL_DEPTH))
		else $error("entry count above pool depth");

	// the ram is only written while a request is in work
	a_wr_busy: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q != ST_IDLE))
		else $error("ram write while idle");

	// the walk never reads past the held entries
	a_rd_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> (rd_ptr_q < count_q))
		else $error("read beyond held entries");

	// a new result only appears out of the final state
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_FIN))
		else $error("result without a finished request");

	// no read is pending when the request finishes
	a_fin_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) |-> !valid_s1)
		else $error("read still in flight at finish");

endmodule

`default_nettype wire

// File: verif/tb_keyed_lifo_id_pool.sv
// ----------------------------------------------------------------------------
// tb_keyed_lifo_id_pool
// Self-checking bench for the keyed lifo id pool. A short table of requests
// covers empty, duplicate, missing and unused-mode cases; random rounds then
// fill, drain and mix the pool while both channels idle and stall at random.
// Results are compared field by field with the table or the pool predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_keyed_lifo_id_pool;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int POOL_DEPTH   = 64;
	localparam int HELD_W       = $clog2(POOL_DEPTH + 1);
	localparam int TARGET_ITEMS = 850;
	localparam int DIR_ROWS     = 19;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = POOL_DEPTH + 16;
	localparam int CYCLE_LIMIT  = 500_000;

	localparam logic [klip_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

	typedef struct packed {
		logic [klip_pkg::STATUS_W-1:0] status;
		klip_pkg::value_t              taken;
		logic [HELD_W-1:0]             held;
	} pool_result_t;

	typedef struct packed {
		logic [klip_pkg::MODE_W-1:0] op;
		klip_pkg::value_t            val;
		bit                          pinned;
		pool_result_t                res;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [klip_pkg::MODE_W-1:0] mode = klip_pkg::MODE_INSERT;
	klip_pkg::value_t item_value = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [klip_pkg::STATUS_W-1:0] status;
	klip_pkg::value_t taken_value;
	logic [HELD_W-1:0] entries_held;

	// predictor state
	klip_pkg::value_t pool_ids [POOL_DEPTH];
	int pool_cnt = 0;

	pool_result_t pending_q[$];
	dir_row_t dir_rows [DIR_ROWS];
	int errors = 0;
	int cycle_count = 0;
	int items_sent = 0;
	int gap_max = 12;
	int hold_len = 0;

	keyed_lifo_id_pool #(
		.POOL_DEPTH(POOL_DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.item_value(item_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.taken_value(taken_value),
		.entries_held(entries_held)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("keyed_lifo_id_pool test failed");
			$finish;
		end
	end

	function automatic pool_result_t predict_pool(logic [klip_pkg::MODE_W-1:0] op,
			klip_pkg::value_t val);
		pool_result_t res;
		int slot;
		res.status = klip_pkg::STAT_OK;
		res.taken = '0;
		slot = -1;
		for (int i = 0; i < pool_cnt; i++) begin
			if (slot < 0 && pool_ids[i] == val)
				slot = i;
		end
		case (op)
		klip_pkg::MODE_INSERT: begin
			// duplicate wins over full
			if (slot >= 0)
				res.status = klip_pkg::STAT_DUP;
			else if (pool_cnt >= POOL_DEPTH)
				res.status = klip_pkg::STAT_FULL;
			else begin
				pool_ids[pool_cnt] = val;
				pool_cnt++;
			end
		end
		klip_pkg::MODE_ERASE: begin
			if (slot < 0)
				res.status = klip_pkg::STAT_MISSING;
			else begin
				for (int i = slot; i < pool_cnt - 1; i++)
					pool_ids[i] = pool_ids[i + 1];
				pool_cnt--;
			end
		end
		klip_pkg::MODE_TAKE: begin
			if (pool_cnt == 0)
				res.status = klip_pkg::STAT_EMPTY;
			else begin
				pool_cnt--;
				res.taken = pool_ids[pool_cnt];
			end
		end
		default: ;
		endcase
		res.held = HELD_W'(pool_cnt);
		return res;
	endfunction

	function automatic klip_pkg::value_t pick_value();
		int r;
		r = $urandom_range(99, 0);
		if (r < 40 && pool_cnt > 0)
			return pool_ids[$urandom_range(pool_cnt - 1, 0)];
		// small ids near zero and near all-ones collide often
		if (r < 50)
			return klip_pkg::value_t'($urandom_range(7, 0));
		if (r < 55)
			return ~klip_pkg::value_t'($urandom_range(7, 0));
		return {$urandom, $urandom};
	endfunction

	function automatic logic [klip_pkg::MODE_W-1:0] pick_mode(int ins_pct, int era_pct);
		int r;
		r = $urandom_range(99, 0);
		if (r < 3)
			return MODE_UNUSED;
		if (r < 3 + ins_pct)
			return klip_pkg::MODE_INSERT;
		if (r < 3 + ins_pct + era_pct)
			return klip_pkg::MODE_ERASE;
		return klip_pkg::MODE_TAKE;
	endfunction

	task automatic send_request(input logic [klip_pkg::MODE_W-1:0] op,
			input klip_pkg::value_t val, input bit pinned, input pool_result_t pin_res);
		int gap;
		pool_result_t res;
		gap = (gap_max == 0) ? 0 : $urandom_range(gap_max, 0);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= op;
		item_value <= val;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		res = predict_pool(op, val);
		pending_q.push_back(pinned ? pin_res : res);
		if (op != MODE_UNUSED)
			items_sent++;
	endtask

	// drop the request line, then wait until every result is back
	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
	endtask

	// result side: random stall per result, or one long hold when asked
	initial begin : result_sink
		int wait_n;
		forever begin
			if (hold_len > 0) begin
				wait_n = hold_len;
				hold_len = 0;
			end else
				wait_n = (gap_max == 0) ? 0 : $urandom_range(gap_max, 0);
			if (wait_n > 0) begin
				out_stall <= 1'b1;
				repeat (wait_n) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (out_valid !== 1'b1) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		pool_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_q.size() == 0) begin
				$display("%0t: result with no request waiting, status %0d taken %h held %0d",
					$time, status, taken_value, entries_held);
				errors++;
			end else begin
				want = pending_q.pop_front();
				if (status !== want.status) begin
					$display("%0t: status mismatch, expected %0d, got %0d",
						$time, want.status, status);
					errors++;
				end
				if (taken_value !== want.taken) begin
					$display("%0t: taken_value mismatch, expected %h, got %h",
						$time, want.taken, taken_value);
					errors++;
				end
				if (entries_held !== want.held) begin
					$display("%0t: entries_held mismatch, expected %0d, got %0d",
						$time, want.held, entries_held);
					errors++;
				end
			end
		end
	end

	initial begin : request_source
		int round_idx;
		int round_len;
		int ins_pct;
		int era_pct;
		logic [klip_pkg::MODE_W-1:0] op;

		dir_rows = '{
			'{klip_pkg::MODE_TAKE, 64'h0, 1'b1,
				'{klip_pkg::STAT_EMPTY, 64'h0, 7'd0}},
			'{klip_pkg::MODE_ERASE, 64'h0, 1'b1,
				'{klip_pkg::STAT_MISSING, 64'h0, 7'd0}},
			'{MODE_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
				'{klip_pkg::STAT_OK, 64'h0, 7'd0}},
			'{klip_pkg::MODE_INSERT, 64'h8000_0000_0000_0000, 1'b1,
				'{klip_pkg::STAT_OK, 64'h0, 7'd1}},
			'{klip_pkg::MODE_INSERT, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1,
				'{klip_pkg::STAT_OK, 64'h0, 7'd2}},
			'{klip_pkg::MODE_INSERT, 64'h0, 1'b1,
				'{klip_pkg::STAT_OK, 64'h0, 7'd3}},
			'{klip_pkg::MODE_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
				'{klip_pkg::STAT_OK, 64'h0, 7'd4}},
			'{klip_pkg::MODE_INSERT, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1,
				'{klip_pkg::STAT_DUP, 64'h0, 7'd4}},
			'{klip_pkg::MODE_ERASE, 64'h0, 1'b1,
				'{klip_pkg::STAT_OK, 64'h0, 7'd3}},
			'{klip_pkg::MODE_ERASE, 64'h0, 1'b1,
				'{klip_pkg::STAT_MISSING, 64'h0, 7'd3}},
			'{klip_pkg::MODE_TAKE, 64'h0, 1'b1,
				'{klip_pkg::STAT_OK, 64'hFFFF_FFFF_FFFF_FFFF, 7'd2}},
			'{klip_pkg::MODE_INSERT, 64'h5555_5555_5555_5555, 1'b1,
				'{klip_pkg::STAT_OK, 64'h0, 7'd3}},
			'{klip_pkg::MODE_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1,
				'{klip_pkg::STAT_OK, 64'h0, 7'd4}},
			'{MODE_UNUSED, 64'h5555_5555_5555_5555, 1'b1,
				'{klip_pkg::STAT_OK, 64'h0, 7'd4}},
			// erase the oldest, the rest keep their order
			'{klip_pkg::MODE_ERASE, 64'h8000_0000_0000_0000, 1'b1,
				'{klip_pkg::STAT_OK, 64'h0, 7'd3}},
			'{klip_pkg::MODE_TAKE, 64'h0, 1'b1,
				'{klip_pkg::STAT_OK, 64'hAAAA_AAAA_AAAA_AAAA, 7'd2}},
			'{klip_pkg::MODE_TAKE, 64'h0, 1'b1,
				'{klip_pkg::STAT_OK, 64'h5555_5555_5555_5555, 7'd1}},
			'{klip_pkg::MODE_TAKE, 64'h0, 1'b1,
				'{klip_pkg::STAT_OK, 64'h7FFF_FFFF_FFFF_FFFF, 7'd0}},
			'{klip_pkg::MODE_TAKE, 64'h0, 1'b1,
				'{klip_pkg::STAT_EMPTY, 64'h0, 7'd0}}
		};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++)
			send_request(dir_rows[i].op, dir_rows[i].val, dir_rows[i].pinned, dir_rows[i].res);

		// random rounds: fill, drain, mixed
		round_idx = 0;
		while (items_sent < TARGET_ITEMS) begin
			case (round_idx % 3)
			0: begin
				ins_pct = 85;
				era_pct = 6;
				round_len = $urandom_range(140, 100);
			end
			1: begin
				ins_pct = 12;
				era_pct = 45;
				round_len = $urandom_range(120, 60);
			end
			default: begin
				ins_pct = 45;
				era_pct = 30;
				round_len = $urandom_range(120, 60);
			end
			endcase
			gap_max = (round_idx % 4 == 3) ? 0 : 12;
			// long receiver hold so the block backs up into its input
			if (round_idx == 2)
				hold_len = HOLD_CYCLES;
			for (int n = 0; n < round_len && items_sent < TARGET_ITEMS; n++) begin
				op = pick_mode(ins_pct, era_pct);
				send_request(op, pick_value(), 1'b0, '0);
			end
			if (round_idx == 0 || $urandom_range(2, 0) == 0)
				wait_for_results();
			round_idx++;
		end

		gap_max = 12;
		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("keyed_lifo_id_pool test passed");
		else
			$display("keyed_lifo_id_pool test failed");
		$finish;
	end

endmodule

`default_nettype wire
